FILE: src/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK   = 3'd0,
		CMD_PUSH_FRONT  = 3'd1,
		CMD_POP_BACK    = 3'd2,
		CMD_POP_FRONT   = 3'd3,
		CMD_INSERT      = 3'd4,
		CMD_ERASE       = 3'd5,
		CMD_ERASE_RANGE = 3'd6,
		CMD_READ        = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// What one cell does in a cycle: keep its word, take the new value,
	// take the word of the cell below it, or take the word of the cell above it.
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_FROM_LOW  = 2'd2,
		CELL_FROM_HIGH = 2'd3
	} cell_op_t;

endpackage

FILE: src/positional_list_engine.sv
// Top level of the positional list engine: command decode, count and the row of cells.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Every command yields exactly one result, shown for one cycle with done high:
// read_value, element_count, free_slots, is_empty and status.
// Push, pop, insert, erase and read report directly: done is high in the
// cycle after the command beat, and busy stays low, so one command can be
// taken every cycle. Insert and erase shift the list at the position
// by one place at once. An erase of the range lo..hi shifts the cells at lo
// and above down one place per cycle, hi - lo + 1 shifts in all, the first
// as the beat is taken; busy is high for the rest, and done follows the last.
// A failed command changes nothing and reports its status in the next cycle.
// Reset empties the list at once; stored words are not cleared, since only
// words below the count are ever read.
// The receiver cannot stall: each result is valid only while done is high.
module positional_list_engine #(
	parameter int CAPACITY = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [2:0]                           command,
	input  logic [ple_pkg::POS_W-1:0]            position,
	input  logic [ple_pkg::POS_W-1:0]            end_position,
	input  logic signed [ple_pkg::VALUE_W-1:0]   value,
	output logic                                 done,
	output logic signed [ple_pkg::VALUE_W-1:0]   read_value,
	output logic [ple_pkg::COUNT_W-1:0]          element_count,
	output logic [ple_pkg::COUNT_W-1:0]          free_slots,
	output logic                                 is_empty,
	output logic [1:0]                           status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

	typedef enum logic {
		S_IDLE,
		S_RANGE
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                count_q;
	logic [CMP_W-1:0]                lo_q;
	logic [ple_pkg::POS_W-1:0]       remain_q;
	logic                            done_q;
	logic [ple_pkg::VALUE_W-1:0]     read_value_q;
	ple_pkg::status_t                status_q;

	logic [DATA_WIDTH-1:0]           cell_data [CAPACITY];
	ple_pkg::cell_op_t               cell_op   [CAPACITY];
	logic [DATA_WIDTH-1:0]           load_data;
	logic [63:0]                     value_wide;
	logic [63:0]                     read_wide;

	logic                            accept;
	ple_pkg::cmd_t                   cmd;
	logic [CMP_W-1:0]                count_x;
	logic [CMP_W-1:0]                pos_x;
	logic [CMP_W-1:0]                end_x;
	logic                            is_full;

	ple_pkg::status_t                status_c;
	logic [CNT_W-1:0]                count_c;
	logic [ple_pkg::VALUE_W-1:0]     read_c;
	logic                            range_go;
	logic                            do_load;
	logic                            do_up;
	logic                            do_down;
	logic [CMP_W-1:0]                load_idx;
	logic [CMP_W-1:0]                down_idx;

	assign accept  = start && (state_q == S_IDLE);
	assign cmd     = ple_pkg::cmd_t'(command);
	assign count_x = CMP_W'(count_q);
	assign pos_x   = CMP_W'(position);
	assign end_x   = CMP_W'(end_position);
	assign is_full = (count_q >= CNT_W'(CAPACITY));

	assign value_wide = 64'($unsigned(value));
	assign load_data  = value_wide[DATA_WIDTH-1:0];
	assign read_wide  = 64'($signed(cell_data[IDX_W'(position)]));

	always_comb begin
		status_c = ple_pkg::ST_OK;
		count_c  = count_q;
		read_c   = '0;
		range_go = 1'b0;
		do_load  = 1'b0;
		do_up    = 1'b0;
		do_down  = 1'b0;
		load_idx = '0;
		down_idx = '0;
		if (state_q == S_RANGE) begin
			do_down  = 1'b1;
			down_idx = lo_q;
			count_c  = count_q - CNT_W'(1);
		end else if (accept) begin
			case (cmd)
				ple_pkg::CMD_PUSH_BACK, ple_pkg::CMD_PUSH_FRONT: begin
					if (is_full) begin
						status_c = ple_pkg::ST_FULL;
					end else begin
						do_load  = 1'b1;
						do_up    = (cmd == ple_pkg::CMD_PUSH_FRONT);
						load_idx = (cmd == ple_pkg::CMD_PUSH_BACK) ? count_x : '0;
						count_c  = count_q + CNT_W'(1);
					end
				end
				ple_pkg::CMD_POP_BACK, ple_pkg::CMD_POP_FRONT: begin
					if (count_q == '0) begin
						status_c = ple_pkg::ST_EMPTY;
					end else begin
						do_down  = (cmd == ple_pkg::CMD_POP_FRONT);
						count_c  = count_q - CNT_W'(1);
					end
				end
				ple_pkg::CMD_INSERT: begin
					if (count_q == '0) begin
						status_c = ple_pkg::ST_EMPTY;
					end else if (pos_x >= count_x) begin
						status_c = ple_pkg::ST_BADPOS;
					end else if (is_full) begin
						status_c = ple_pkg::ST_FULL;
					end else begin
						do_load  = 1'b1;
						do_up    = 1'b1;
						load_idx = pos_x;
						count_c  = count_q + CNT_W'(1);
					end
				end
				ple_pkg::CMD_ERASE: begin
					if (pos_x >= count_x) begin
						status_c = ple_pkg::ST_BADPOS;
					end else begin
						do_down  = 1'b1;
						down_idx = pos_x;
						count_c  = count_q - CNT_W'(1);
					end
				end
				ple_pkg::CMD_ERASE_RANGE: begin
					if (pos_x >= end_x || end_x >= count_x) begin
						status_c = ple_pkg::ST_BADPOS;
					end else begin
						// First of hi - lo + 1 single-place shifts happens now.
						do_down  = 1'b1;
						down_idx = pos_x;
						count_c  = count_q - CNT_W'(1);
						range_go = 1'b1;
					end
				end
				default: begin
					if (pos_x >= count_x) begin
						status_c = ple_pkg::ST_BADPOS;
					end else begin
						read_c = read_wide[ple_pkg::VALUE_W-1:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_load && CMP_W'(i) == load_idx) begin
				cell_op[i] = ple_pkg::CELL_LOAD;
			end else if (do_up && CMP_W'(i) > load_idx) begin
				cell_op[i] = ple_pkg::CELL_FROM_LOW;
			end else if (do_down && CMP_W'(i) >= down_idx) begin
				cell_op[i] = ple_pkg::CELL_FROM_HIGH;
			end else begin
				cell_op[i] = ple_pkg::CELL_HOLD;
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;
		if (g == 0) begin : g_first
			assign lower = '0;
		end else begin : g_inner_low
			assign lower = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign upper = cell_data[g];
		end else begin : g_inner_high
			assign upper = cell_data[g+1];
		end
		ple_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (cell_op[g]),
			.load_data  (load_data),
			.lower_data (lower),
			.upper_data (upper),
			.data       (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			lo_q         <= '0;
			remain_q     <= '0;
			done_q       <= 1'b0;
			read_value_q <= '0;
			status_q     <= ple_pkg::ST_OK;
		end else begin
			count_q <= count_c;
			done_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (range_go) begin
							state_q  <= S_RANGE;
							lo_q     <= pos_x;
							remain_q <= end_position - position;
						end else begin
							done_q       <= 1'b1;
							read_value_q <= read_c;
							status_q     <= status_c;
						end
					end
				end
				S_RANGE: begin
					remain_q <= remain_q - ple_pkg::POS_W'(1);
					if (remain_q == ple_pkg::POS_W'(1)) begin
						state_q      <= S_IDLE;
						done_q       <= 1'b1;
						read_value_q <= '0;
						status_q     <= ple_pkg::ST_OK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q == S_RANGE);
	assign done          = done_q;
	assign read_value    = read_value_q;
	assign status        = status_q;
	assign element_count = ple_pkg::COUNT_W'(count_q);
	assign free_slots    = ple_pkg::COUNT_W'(CNT_W'(CAPACITY) - count_q);
	assign is_empty      = (count_q == '0);

endmodule

FILE: src/ple_cell.sv
// One storage cell of the list: a word register fed by the new value or by its two neighbors.
module ple_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  ple_pkg::cell_op_t     op,
	input  logic [DATA_WIDTH-1:0] load_data,
	input  logic [DATA_WIDTH-1:0] lower_data,
	input  logic [DATA_WIDTH-1:0] upper_data,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			ple_pkg::CELL_LOAD:      data_q <= load_data;
			ple_pkg::CELL_FROM_LOW:  data_q <= lower_data;
			ple_pkg::CELL_FROM_HIGH: data_q <= upper_data;
			default:                 data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

FILE: src/ple_checker.sv
// Port-level checks for the positional list engine and their binding.
module ple_checker #(
	parameter int CAPACITY = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [ple_pkg::COUNT_W-1:0]    element_count,
	input logic [ple_pkg::COUNT_W-1:0]    free_slots,
	input logic [1:0]                     status
);

	// An accepted beat either reports next cycle or starts a range shift.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted command neither reported nor went busy");

	// The end of a range shift is always reported in the same cycle.
	a_range_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("range erase ended without a result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		ple_pkg::COUNT_W'(element_count + free_slots) == ple_pkg::COUNT_W'(CAPACITY))
		else $error("count and free slots disagree with capacity");

	// A failed command leaves the count where it was.
	a_error_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ple_pkg::ST_OK |-> element_count == $past(element_count))
		else $error("failed command changed the count");

endmodule

bind positional_list_engine ple_checker #(
	.CAPACITY(CAPACITY)
) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.element_count (element_count),
	.free_slots    (free_slots),
	.status        (status)
);

FILE: bench/positional_list_engine_tb.sv
// Self-checking testbench for the positional list engine: corner cases, then random traffic.
`timescale 1ns / 100ps

module positional_list_engine_tb;

	localparam int LIST_DEPTH = 16;
	localparam int PENDING_DEPTH = 64;

	typedef struct {
		logic signed [ple_pkg::VALUE_W-1:0] rd;
		logic [ple_pkg::COUNT_W-1:0]        cnt;
		logic [ple_pkg::COUNT_W-1:0]        fr;
		logic                               emp;
		ple_pkg::status_t                   st;
	} list_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [2:0]                         command;
	logic [ple_pkg::POS_W-1:0]          position;
	logic [ple_pkg::POS_W-1:0]          end_position;
	logic signed [ple_pkg::VALUE_W-1:0] value;
	logic                               done;
	logic signed [ple_pkg::VALUE_W-1:0] read_value;
	logic [ple_pkg::COUNT_W-1:0]        element_count;
	logic [ple_pkg::COUNT_W-1:0]        free_slots;
	logic                               is_empty;
	logic [1:0]                         status;

	// Shadow copy of the list, updated as each command beat is accepted.
	logic signed [ple_pkg::VALUE_W-1:0] shadow_words [LIST_DEPTH];
	int                                 shadow_len = 0;
	// Results still owed by the block, oldest at pending_head.
	list_result_t                       expected_results [PENDING_DEPTH];
	int                                 pending_head = 0;
	int                                 pending_tail = 0;

	int  mismatch_count = 0;
	int  commands_sent = 0;
	int  results_checked = 0;
	int  status_seen [4] = '{0, 0, 0, 0};
	int  peak_len = 0;
	bit  allow_gaps = 1'b1;

	positional_list_engine #(
		.CAPACITY(LIST_DEPTH),
		.DATA_WIDTH(ple_pkg::VALUE_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.end_position(end_position),
		.value(value),
		.done(done),
		.read_value(read_value),
		.element_count(element_count),
		.free_slots(free_slots),
		.is_empty(is_empty),
		.status(status)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Opens a gap at pos and writes the word there; the caller checks for room.
	function automatic void open_slot(input int pos,
			input logic signed [ple_pkg::VALUE_W-1:0] word);
		for (int i = shadow_len; i > pos; i--) begin
			shadow_words[i] = shadow_words[i-1];
		end
		shadow_words[pos] = word;
		shadow_len++;
	endfunction

	// Removes entries lo..hi inclusive and closes the gap.
	function automatic void close_span(input int lo, input int hi);
		int gone;
		gone = hi - lo + 1;
		for (int i = hi + 1; i < shadow_len; i++) begin
			shadow_words[i-gone] = shadow_words[i];
		end
		shadow_len -= gone;
	endfunction

	function automatic list_result_t apply_list_cmd(input ple_pkg::cmd_t op,
			input logic [ple_pkg::POS_W-1:0] pos, input logic [ple_pkg::POS_W-1:0] last,
			input logic signed [ple_pkg::VALUE_W-1:0] word);
		list_result_t res;
		int n;
		int p;
		int e;
		n = shadow_len;
		p = pos;
		e = last;
		res.rd = '0;
		res.st = ple_pkg::ST_OK;
		case (op)
			ple_pkg::CMD_PUSH_BACK, ple_pkg::CMD_PUSH_FRONT: begin
				if (n >= LIST_DEPTH) res.st = ple_pkg::ST_FULL;
				else open_slot((op == ple_pkg::CMD_PUSH_BACK) ? n : 0, word);
			end
			ple_pkg::CMD_POP_BACK: begin
				if (n == 0) res.st = ple_pkg::ST_EMPTY;
				else shadow_len = n - 1;
			end
			ple_pkg::CMD_POP_FRONT: begin
				if (n == 0) res.st = ple_pkg::ST_EMPTY;
				else close_span(0, 0);
			end
			ple_pkg::CMD_INSERT: begin
				// An empty list wins over a bad position.
				if (n == 0) res.st = ple_pkg::ST_EMPTY;
				else if (p >= n) res.st = ple_pkg::ST_BADPOS;
				else if (n >= LIST_DEPTH) res.st = ple_pkg::ST_FULL;
				else open_slot(p, word);
			end
			ple_pkg::CMD_ERASE: begin
				if (p >= n) res.st = ple_pkg::ST_BADPOS;
				else close_span(p, p);
			end
			ple_pkg::CMD_ERASE_RANGE: begin
				if (p >= e || e >= n) res.st = ple_pkg::ST_BADPOS;
				else close_span(p, e);
			end
			default: begin
				if (p >= n) res.st = ple_pkg::ST_BADPOS;
				else res.rd = shadow_words[p];
			end
		endcase
		res.cnt = ple_pkg::COUNT_W'(shadow_len);
		res.fr = ple_pkg::COUNT_W'(LIST_DEPTH - shadow_len);
		res.emp = (shadow_len == 0);
		return res;
	endfunction

	// Drives one command beat, holds it until accepted, then records the expected result.
	task automatic issue_cmd(input ple_pkg::cmd_t op, input logic [ple_pkg::POS_W-1:0] pos,
			input logic [ple_pkg::POS_W-1:0] last,
			input logic signed [ple_pkg::VALUE_W-1:0] word);
		int gap;
		list_result_t res;
		if (allow_gaps && $urandom_range(99) < 10) begin
			gap = $urandom_range(3, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= op;
		position <= pos;
		end_position <= last;
		value <= word;
		do @(posedge clk); while (busy !== 1'b0);
		res = apply_list_cmd(op, pos, last, word);
		expected_results[pending_tail % PENDING_DEPTH] = res;
		pending_tail++;
		commands_sent++;
		status_seen[res.st]++;
		if (shadow_len > peak_len) peak_len = shadow_len;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_tail != pending_head) @(posedge clk);
	endtask

	function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_word();
		logic signed [ple_pkg::VALUE_W-1:0] w;
		case ($urandom_range(19))
			0: w = 32'sh8000_0000;
			1: w = 32'sh7FFF_FFFF;
			2: w = '0;
			3: w = -32'sd1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_tail == pending_head) begin
				report_mismatch("result beat with no command waiting for it");
			end else begin
				want = expected_results[pending_head % PENDING_DEPTH];
				pending_head++;
				results_checked++;
				if (read_value !== want.rd)
					report_mismatch($sformatf("read_value got %0d want %0d", read_value, want.rd));
				if (element_count !== want.cnt)
					report_mismatch($sformatf("element_count got %0d want %0d",
						element_count, want.cnt));
				if (free_slots !== want.fr)
					report_mismatch($sformatf("free_slots got %0d want %0d", free_slots, want.fr));
				if (is_empty !== want.emp)
					report_mismatch($sformatf("is_empty got %b want %b", is_empty, want.emp));
				if (status !== want.st)
					report_mismatch($sformatf("status got %0d want %0d", status, want.st));
			end
		end
	end

	// Every command but a push must fail on an empty list without touching the state.
	task automatic test_empty_list();
		issue_cmd(ple_pkg::CMD_POP_BACK, 4'd0, 4'd0, 32'sd5);
		issue_cmd(ple_pkg::CMD_POP_FRONT, 4'd0, 4'd0, 32'sd5);
		issue_cmd(ple_pkg::CMD_INSERT, 4'd15, 4'd0, 32'sd9);
		issue_cmd(ple_pkg::CMD_ERASE, 4'd0, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_READ, 4'd0, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE_RANGE, 4'd0, 4'd1, 32'sd0);
	endtask

	// Extreme words, insert and range rules on a short list.
	task automatic test_edge_values();
		issue_cmd(ple_pkg::CMD_PUSH_BACK, 4'd0, 4'd0, 32'sh7FFF_FFFF);
		issue_cmd(ple_pkg::CMD_PUSH_FRONT, 4'd0, 4'd0, 32'sh8000_0000);
		issue_cmd(ple_pkg::CMD_INSERT, 4'd1, 4'd0, -32'sd1);
		issue_cmd(ple_pkg::CMD_INSERT, 4'd3, 4'd0, 32'sd1);
		issue_cmd(ple_pkg::CMD_INSERT, 4'd15, 4'd0, 32'sd1);
		issue_cmd(ple_pkg::CMD_READ, 4'd15, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_READ, 4'd2, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE_RANGE, 4'd1, 4'd1, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE_RANGE, 4'd2, 4'd1, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE_RANGE, 4'd0, 4'd3, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE_RANGE, 4'd0, 4'd1, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE, 4'd1, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_READ, 4'd0, 4'd0, 32'sd0);
	endtask

	// Fills the list, checks the full errors, then clears it with the widest range.
	task automatic test_full_list();
		while (shadow_len < LIST_DEPTH) begin
			issue_cmd(($urandom_range(1) != 0) ? ple_pkg::CMD_PUSH_BACK : ple_pkg::CMD_PUSH_FRONT,
				4'($urandom), 4'($urandom), pick_word());
		end
		issue_cmd(ple_pkg::CMD_PUSH_BACK, 4'd0, 4'd0, 32'sd7);
		issue_cmd(ple_pkg::CMD_PUSH_FRONT, 4'd0, 4'd0, 32'sd7);
		issue_cmd(ple_pkg::CMD_INSERT, 4'd0, 4'd0, 32'sd7);
		issue_cmd(ple_pkg::CMD_INSERT, 4'd15, 4'd0, 32'sd7);
		issue_cmd(ple_pkg::CMD_READ, 4'd15, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_ERASE, 4'd15, 4'd0, 32'sd0);
		issue_cmd(ple_pkg::CMD_PUSH_FRONT, 4'd0, 4'd0, -32'sd2);
		issue_cmd(ple_pkg::CMD_ERASE_RANGE, 4'd0, 4'd15, 32'sd0);
	endtask

	// Alternates between growing and shrinking so the list swings between empty and full.
	task automatic test_random_traffic(input int item_total);
		int r;
		int lo;
		int hi;
		bit grow;
		ple_pkg::cmd_t op;
		logic [ple_pkg::POS_W-1:0] pos;
		logic [ple_pkg::POS_W-1:0] last;
		for (int i = 0; i < item_total; i++) begin
			allow_gaps = !(i >= 150 && i < 260);
			if (i == 300) wait_idle();
			grow = ((i / 45) % 2) == 0;
			r = $urandom_range(99);
			if (grow) begin
				if (r < 40)
					op = ($urandom_range(1) != 0) ? ple_pkg::CMD_PUSH_BACK : ple_pkg::CMD_PUSH_FRONT;
				else if (r < 60) op = ple_pkg::CMD_INSERT;
				else if (r < 70)
					op = ($urandom_range(1) != 0) ? ple_pkg::CMD_POP_BACK : ple_pkg::CMD_POP_FRONT;
				else if (r < 80) op = ple_pkg::CMD_ERASE;
				else if (r < 85) op = ple_pkg::CMD_ERASE_RANGE;
				else op = ple_pkg::CMD_READ;
			end else begin
				if (r < 10)
					op = ($urandom_range(1) != 0) ? ple_pkg::CMD_PUSH_BACK : ple_pkg::CMD_PUSH_FRONT;
				else if (r < 15) op = ple_pkg::CMD_INSERT;
				else if (r < 45)
					op = ($urandom_range(1) != 0) ? ple_pkg::CMD_POP_BACK : ple_pkg::CMD_POP_FRONT;
				else if (r < 65) op = ple_pkg::CMD_ERASE;
				else if (r < 80) op = ple_pkg::CMD_ERASE_RANGE;
				else op = ple_pkg::CMD_READ;
			end
			pos = 4'($urandom);
			last = 4'($urandom);
			// Mostly legal positions, with some noise to hit the bad-position path.
			if ($urandom_range(99) < 85) begin
				if (op == ple_pkg::CMD_ERASE_RANGE && shadow_len >= 2) begin
					lo = $urandom_range(shadow_len - 2);
					hi = $urandom_range(shadow_len - 1, lo + 1);
					pos = 4'(lo);
					last = 4'(hi);
				end else if (shadow_len > 0) begin
					pos = 4'($urandom_range(shadow_len - 1));
				end
			end
			issue_cmd(op, pos, last, pick_word());
		end
	endtask

	initial begin
		start <= 1'b0;
		command <= ple_pkg::CMD_READ;
		position <= '0;
		end_position <= '0;
		value <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edge_values();
		test_full_list();
		test_random_traffic(450);
		wait_idle();
		// Let any trailing range erase finish before the verdict.
		repeat (20) @(posedge clk);
		$display("Sent %0d commands, checked %0d results, list peaked at %0d entries.",
			commands_sent, results_checked, peak_len);
		$display("Status mix: ok %0d, full %0d, empty %0d, bad position %0d.",
			status_seen[ple_pkg::ST_OK], status_seen[ple_pkg::ST_FULL],
			status_seen[ple_pkg::ST_EMPTY], status_seen[ple_pkg::ST_BADPOS]);
		if (mismatch_count == 0) begin
			$display("positional_list_engine: match");
		end else begin
			$display("positional_list_engine: mismatch");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results still expected.", pending_tail - pending_head);
		$display("positional_list_engine: mismatch");
		$finish;
	end

endmodule
